[src/field_oriented_omni_drive_mixer_assert.svh]
`ifndef FIELD_ORIENTED_OMNI_DRIVE_MIXER_ASSERT_SVH
`define FIELD_ORIENTED_OMNI_DRIVE_MIXER_ASSERT_SVH

// Same-cycle implication on clk_i, muted while rst_ni is low.
`define FODM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fodm: check failed");

// Next-cycle implication on clk_i, muted while rst_ni is low.
`define FODM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fodm: check failed");

`endif

[src/fodm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fodm_pkg;

  localparam int ANGLE_FRAC_BITS = 4;
  localparam int TRIG_FRAC_BITS  = 15;

  localparam int FullTurn    = 360 << ANGLE_FRAC_BITS;
  localparam int HalfTurn    = 180 << ANGLE_FRAC_BITS;
  localparam int QuarterTurn = 90 << ANGLE_FRAC_BITS;
  localparam int EighthTurn  = 45 << ANGLE_FRAC_BITS;

  // heading - rotation is lifted positive by a whole number of turns
  localparam int WrapOffset = 6 * FullTurn;
  localparam int WrapShift  = 29;
  localparam longint WrapRecip = ((64'sd1 << WrapShift) + FullTurn - 1) / FullTurn;

  // pi in Q30, split so that a * pi / half turn needs no wide divide
  localparam longint PiQ30    = 64'sd3373259426;
  localparam longint PiQuot   = PiQ30 / HalfTurn;
  localparam longint PiRem    = PiQ30 - PiQuot * HalfTurn;
  localparam int     PiShift  = 33;
  localparam longint PiRecip  = ((64'sd1 << PiShift) + HalfTurn - 1) / HalfTurn;

  localparam int TrigShift = 30 - TRIG_FRAC_BITS;
  localparam int TrigHalf  = 1 << (TrigShift - 1);

  localparam int HornerSteps = 5;
  localparam int TRIG_LAT    = 4 + 3 * HornerSteps;
  localparam int CURVE_LAT   = 6;

  localparam logic [30:0] OneQ30 = 31'h4000_0000;

  typedef struct packed {
    logic signed [15:0] rotation_angle;
    logic signed [7:0]  stick_forward;
    logic signed [7:0]  stick_side;
    logic signed [7:0]  stick_turn;
  } fodm_in_t;

  typedef struct packed {
    logic signed [11:0] north_power;
    logic signed [11:0] south_power;
    logic signed [11:0] east_power;
    logic signed [11:0] west_power;
  } fodm_out_t;

  // lane 0 is the sine series, lane 1 the cosine series
  function automatic logic [6:0] horner_div(input int lane, input int step);
    logic [6:0] d;
    if (lane == 0) begin
      unique case (step)
        0:       d = 7'd72;
        1:       d = 7'd42;
        2:       d = 7'd20;
        3:       d = 7'd6;
        default: d = 7'd2;
      endcase
    end else begin
      unique case (step)
        0:       d = 7'd90;
        1:       d = 7'd56;
        2:       d = 7'd30;
        3:       d = 7'd12;
        default: d = 7'd2;
      endcase
    end
    return d;
  endfunction

  // floor(2^31 / divisor), held just below 2^30 for the halving step so that it
  // fits; the single correction step absorbs the shortfall
  function automatic logic [29:0] horner_recip(input int lane, input int step);
    logic [29:0] k;
    if (lane == 0) begin
      unique case (step)
        0:       k = 30'd29826161;
        1:       k = 30'd51130563;
        2:       k = 30'd107374182;
        3:       k = 30'd357913941;
        default: k = 30'd1073741823;
      endcase
    end else begin
      unique case (step)
        0:       k = 30'd23860929;
        1:       k = 30'd38347922;
        2:       k = 30'd71582788;
        3:       k = 30'd178956970;
        default: k = 30'd1073741823;
      endcase
    end
    return k;
  endfunction

endpackage

`default_nettype wire

[src/fodm_trig.sv]
`timescale 1ns / 1ps
`default_nettype none

module fodm_trig (
  input  logic                          clk_i,
  input  logic [fodm_pkg::TRIG_LAT-1:0] en_i,
  input  logic [9:0]                    angle_i,
  output logic [30:0]                   sin_o,
  output logic [30:0]                   cos_o
);
  import fodm_pkg::*;

  localparam int Subs = 3 * HornerSteps;

  typedef struct packed {
    logic [29:0] r;
    logic [29:0] r2;
  } car_t;

  logic [29:0] ma_q, ma2_q, r_q;
  logic [20:0] mb_q;
  logic [9:0]  qb_q;
  logic [42:0] pi_prod;
  logic [59:0] rr_prod;

  car_t        car_q [Subs-2];
  logic [30:0] pa_q  [2][HornerSteps];
  logic [30:0] pb_q  [2][HornerSteps];
  logic [30:0] qq_q  [2][HornerSteps];
  logic [30:0] t_q   [2][HornerSteps];

  logic [30:0] t_in   [2][HornerSteps];
  logic [60:0] mul_w  [2][HornerSteps];
  logic [59:0] rec_w  [2][HornerSteps];
  logic [30:0] rem_w  [2][HornerSteps];
  logic [30:0] quo_w  [2][HornerSteps];
  logic [30:0] t_d    [2][HornerSteps];

  assign pi_prod = mb_q * 22'(PiRecip);
  assign rr_prod = r_q * r_q;

  // radians in Q30: a * pi / half turn, rounded half up
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ma_q <= {20'b0, angle_i} * 30'(PiQuot);
      mb_q <= {11'b0, angle_i} * 21'(PiRem) + 21'(HalfTurn / 2);
    end
    if (en_i[1]) begin
      ma2_q <= ma_q;
      qb_q  <= pi_prod[42:33];
    end
    if (en_i[2]) begin
      r_q <= ma2_q + 30'(qb_q);
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      t_in[l][0] = OneQ30;
      for (int k = 1; k < HornerSteps; k++) begin
        t_in[l][k] = t_q[l][k-1];
      end
      for (int k = 0; k < HornerSteps; k++) begin
        // the closing sine step multiplies by r instead of r squared
        if (l == 0 && k == HornerSteps - 1) begin
          mul_w[l][k] = {31'b0, car_q[3*k].r} * {30'b0, t_in[l][k]};
        end else begin
          mul_w[l][k] = {31'b0, car_q[3*k].r2} * {30'b0, t_in[l][k]};
        end
        rec_w[l][k] = {29'b0, pa_q[l][k]} * {30'b0, horner_recip(l, k)};
        rem_w[l][k] = pb_q[l][k] - qq_q[l][k] * 31'(horner_div(l, k));
        quo_w[l][k] = qq_q[l][k] + 31'(rem_w[l][k] >= 31'(horner_div(l, k)));
        if (l == 0 && k == HornerSteps - 1) begin
          t_d[l][k] = pb_q[l][k];
        end else begin
          t_d[l][k] = OneQ30 - quo_w[l][k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      car_q[0] <= '{r: r_q, r2: rr_prod[59:30]};
    end
    for (int j = 1; j < Subs - 2; j++) begin
      if (en_i[3+j]) begin
        car_q[j] <= car_q[j-1];
      end
    end
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < HornerSteps; k++) begin
        if (en_i[4+3*k]) begin
          pa_q[l][k] <= mul_w[l][k][60:30];
        end
        if (en_i[5+3*k]) begin
          pb_q[l][k] <= pa_q[l][k];
          qq_q[l][k] <= {2'b0, rec_w[l][k][59:31]};
        end
        if (en_i[6+3*k]) begin
          t_q[l][k] <= t_d[l][k];
        end
      end
    end
  end

  assign sin_o = t_q[0][HornerSteps-1];
  assign cos_o = t_q[1][HornerSteps-1];

endmodule

`default_nettype wire

[src/fodm_curve.sv]
`timescale 1ns / 1ps
`default_nettype none

module fodm_curve (
  input  logic                           clk_i,
  input  logic [fodm_pkg::CURVE_LAT-1:0] en_i,
  input  logic signed [26:0]             v_i,
  output logic signed [13:0]             curve_o
);
  import fodm_pkg::*;

  localparam int CurveDen = 30000;
  localparam int CurveShift = 28;
  localparam int CurveRecip = (1 << CurveShift) / CurveDen;

  logic [26:0]        mag1;
  logic [26:0]        wsum;
  logic signed [17:0] w_d;
  logic signed [17:0] w1_q, w2w_q;
  logic signed [35:0] w2_q;
  logic signed [53:0] cube_d;
  logic signed [31:0] lin_d;
  logic signed [48:0] cube_q, lin_q;
  logic signed [48:0] n_d;
  logic [47:0]        nmag, nsum;
  logic [27:0]        m2_q, m2c_q;
  logic               neg4_q, neg5_q;
  logic [41:0]        qprod;
  logic [13:0]        q0_q;
  logic [27:0]        rem;
  logic [13:0]        quo;

  always_comb begin
    mag1 = v_i[26] ? 27'(-v_i) : v_i;
    wsum = mag1 + 27'd64;
    w_d = v_i[26] ? -$signed({1'b0, wsum[23:7]}) : $signed({1'b0, wsum[23:7]});
    cube_d = w2_q * w2w_q;
    lin_d = w2w_q * 32'sd10000;
    n_d = cube_q + lin_q;
    nmag = n_d[48] ? 48'(-n_d) : n_d[47:0];
    nsum = nmag + 48'd15728640000;
    qprod = m2_q * 14'(CurveRecip);
    rem = m2c_q - {14'b0, q0_q} * 28'(CurveDen);
    quo = q0_q + 14'(rem >= 28'(CurveDen));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      w1_q <= w_d;
    end
    if (en_i[1]) begin
      w2_q  <= w1_q * w1_q;
      w2w_q <= w1_q;
    end
    if (en_i[2]) begin
      cube_q <= cube_d[48:0];
      lin_q  <= 49'(lin_d) << 16;
    end
    if (en_i[3]) begin
      m2_q   <= nsum[47:20];
      neg4_q <= n_d[48];
    end
    if (en_i[4]) begin
      q0_q   <= qprod[41:28];
      m2c_q  <= m2_q;
      neg5_q <= neg4_q;
    end
    if (en_i[5]) begin
      curve_o <= neg5_q ? -$signed(quo) : $signed(quo);
    end
  end

endmodule

`default_nettype wire

[src/field_oriented_omni_drive_mixer.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Payload       Handshake
// input     in         fodm_in_t     in_valid_i / in_stall_o
// output    out        fodm_out_t    out_valid_o / out_stall_i
// config    in         13-bit word   cfg_we_i
//
// One transfer in per clock while in_stall_o is low; results leave in input order.
// The path runs through the 19-stage radians, sine and cosine Horner pipeline and the
// 6-stage cubic curve. rst_ni clears the stage valid bits and the heading.
// A stalled result holds; earlier stages keep moving into empty slots, so the
// input stalls only once every stage is full.

module field_oriented_omni_drive_mixer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [12:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fodm_pkg::fodm_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fodm_pkg::fodm_out_t out_data_o
);
  import fodm_pkg::*;

  localparam int StTrigIn  = 3;
  localparam int TrigOut   = StTrigIn + TRIG_LAT - 1;
  localparam int StRot     = TrigOut + 1;
  localparam int StMul     = StRot + 1;
  localparam int StSum     = StMul + 1;
  localparam int StCurveIn = StSum + 1;
  localparam int CurveOut  = StCurveIn + CURVE_LAT - 1;
  localparam int StOut     = CurveOut + 1;
  localparam int NumStages = StOut + 1;

  typedef struct packed {
    logic signed [8:0] x;
    logic signed [7:0] y;
    logic signed [7:0] turn;
    logic              sneg;
    logic              cneg;
    logic              swap;
  } side_t;

  logic [12:0]          heading_q;
  logic [NumStages-1:0] valid_q, ready;
  side_t                side_q [CurveOut+1];
  side_t                side_in;
  side_t                side2_d;

  logic signed [17:0] u_s;
  logic [33:0]        wprod;
  logic [16:0]        u_q, m17;
  logic [4:0]         q_q;
  logic signed [13:0] d_d, d_q;
  logic [12:0]        m13;
  logic [11:0]        a0, a1;
  logic [9:0]         a2, a_q;
  logic               cneg_d, swap_d;

  logic [30:0]        sin_t, cos_t;
  logic [31:0]        s_sum, c_sum;
  logic [15:0]        smag, cmag;
  logic signed [16:0] s_q, c_q;
  logic signed [25:0] xc_q, ys_q, xs_q, yc_q;
  logic signed [26:0] left_q, right_q;
  logic signed [13:0] curve_l, curve_r;
  logic signed [10:0] ht;
  fodm_out_t          out_q;

  function automatic logic signed [11:0] sat12(input logic signed [14:0] p);
    if (p > 15'sd1600) begin
      return 12'sd1600;
    end else if (p < -15'sd1600) begin
      return -12'sd1600;
    end else begin
      return p[11:0];
    end
  endfunction

  // a stage advances unless it and every stage after it are full and the result stalls
  always_comb begin
    for (int i = 0; i < NumStages; i++) begin
      ready[i] = !out_stall_i || !(&(valid_q | ~({NumStages{1'b1}} << i)));
    end
  end

  assign in_stall_o  = !ready[0];
  assign out_valid_o = valid_q[StOut];
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_q <= '0;
      valid_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        heading_q <= cfg_wdata_i;
      end
      if (ready[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (ready[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  always_comb begin
    side_in.x    = 9'sd0 - $signed({in_data_i.stick_side[7], in_data_i.stick_side});
    side_in.y    = in_data_i.stick_forward;
    side_in.turn = in_data_i.stick_turn;
    side_in.sneg = 1'b0;
    side_in.cneg = 1'b0;
    side_in.swap = 1'b0;

    u_s = $signed({5'b0, heading_q}) + $signed(18'(WrapOffset))
        - $signed({{2{in_data_i.rotation_angle[15]}}, in_data_i.rotation_angle});
    wprod = {17'b0, u_s[16:0]} * 34'(WrapRecip);

    m17 = u_q - {12'b0, q_q} * 17'(FullTurn);
    m13 = m17[12:0];
    d_d = (m13 > 13'(HalfTurn)) ? $signed({1'b0, m13}) - 14'(FullTurn)
                                 : $signed({1'b0, m13});

    // fold into the first octant
    a0 = d_q[13] ? 12'(-d_q) : d_q[11:0];
    cneg_d = a0 > 12'(QuarterTurn);
    a1 = cneg_d ? 12'(HalfTurn) - a0 : a0;
    swap_d = a1 > 12'(EighthTurn);
    a2 = swap_d ? 10'(12'(QuarterTurn) - a1) : a1[9:0];

    side2_d      = side_q[1];
    side2_d.sneg = d_q[13];
    side2_d.cneg = cneg_d;
    side2_d.swap = swap_d;

    s_sum = {1'b0, sin_t} + 32'(TrigHalf);
    c_sum = {1'b0, cos_t} + 32'(TrigHalf);
    smag = side_q[TrigOut].swap ? c_sum[TrigShift +: 16] : s_sum[TrigShift +: 16];
    cmag = side_q[TrigOut].swap ? s_sum[TrigShift +: 16] : c_sum[TrigShift +: 16];

    ht = $signed({side_q[CurveOut].turn, 3'b000});
  end

  always_ff @(posedge clk_i) begin
    if (ready[0]) begin
      u_q       <= u_s[16:0];
      q_q       <= wprod[WrapShift +: 5];
      side_q[0] <= side_in;
    end
    if (ready[1]) begin
      d_q       <= d_d;
      side_q[1] <= side_q[0];
    end
    if (ready[2]) begin
      a_q       <= a2;
      side_q[2] <= side2_d;
    end
    for (int i = StTrigIn; i <= CurveOut; i++) begin
      if (ready[i]) begin
        side_q[i] <= side_q[i-1];
      end
    end
    if (ready[StRot]) begin
      s_q <= side_q[TrigOut].sneg ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
      c_q <= side_q[TrigOut].cneg ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
    end
    if (ready[StMul]) begin
      xc_q <= side_q[StRot].x * c_q;
      ys_q <= side_q[StRot].y * s_q;
      xs_q <= side_q[StRot].x * s_q;
      yc_q <= side_q[StRot].y * c_q;
    end
    if (ready[StSum]) begin
      left_q  <= 27'(xc_q) - 27'(ys_q);
      right_q <= 27'(xs_q) + 27'(yc_q);
    end
    if (ready[StOut]) begin
      out_q.north_power <= sat12(15'(curve_l) + 15'(ht));
      out_q.south_power <= sat12(15'(curve_l) - 15'(ht));
      out_q.east_power  <= sat12(15'(curve_r) + 15'(ht));
      out_q.west_power  <= sat12(15'(curve_r) - 15'(ht));
    end
  end

  fodm_trig u_trig (
    .clk_i   (clk_i),
    .en_i    (ready[StTrigIn +: TRIG_LAT]),
    .angle_i (a_q),
    .sin_o   (sin_t),
    .cos_o   (cos_t)
  );

  fodm_curve u_curve_left (
    .clk_i   (clk_i),
    .en_i    (ready[StCurveIn +: CURVE_LAT]),
    .v_i     (left_q),
    .curve_o (curve_l)
  );

  fodm_curve u_curve_right (
    .clk_i   (clk_i),
    .en_i    (ready[StCurveIn +: CURVE_LAT]),
    .v_i     (right_q),
    .curve_o (curve_r)
  );

`include "field_oriented_omni_drive_mixer_assert.svh"

  // an empty first stage always takes a transfer
  `FODM_ASSERT_IMP(a_bubble_takes, !valid_q[0], !in_stall_o)

  // wrapped angle error lies in (-180, 180] degrees
  `FODM_ASSERT_IMP(a_wrap_range, valid_q[1], (d_q > -14'sd2880) && (d_q <= 14'sd2880))

  // unsaturated powers differ by the same turn term on both sides
  `FODM_ASSERT_IMP(a_turn_balance, out_valid_o && (out_data_o.north_power < 12'sd1600) && (out_data_o.north_power > -12'sd1600) && (out_data_o.south_power < 12'sd1600) && (out_data_o.south_power > -12'sd1600) && (out_data_o.east_power < 12'sd1600) && (out_data_o.east_power > -12'sd1600) && (out_data_o.west_power < 12'sd1600) && (out_data_o.west_power > -12'sd1600), (13'(out_data_o.north_power) - 13'(out_data_o.south_power)) == (13'(out_data_o.east_power) - 13'(out_data_o.west_power)))

endmodule

`default_nettype wire

[tb/sv/tb_field_oriented_omni_drive_mixer.sv]
`timescale 1ns / 1ps

module tb_field_oriented_omni_drive_mixer;
  import fodm_pkg::*;

  localparam longint unsigned PiQ30Const = 64'd3373259426;
  localparam longint unsigned OneQ30Val  = 64'd1 << 30;
  localparam int              PowerLimit = 1600;
  localparam int              Latency    = 32;
  localparam int              CycleLimit = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [12:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  fodm_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  fodm_out_t   out_data;

  logic [12:0] heading = '0;
  fodm_out_t   pending_powers[$];
  int          cycle_cnt = 0;
  int          fail_cnt = 0;
  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;
  logic        hold_start = 1'b0;
  int          stall_left = 0;

  field_oriented_omni_drive_mixer u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------- predictor ----------------
  function automatic longint unsigned mul_q30(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  function automatic longint round_to_trig(longint unsigned q);
    return longint'((q + (64'd1 << (TrigShift - 1))) >> TrigShift);
  endfunction

  function automatic void octant_sin_cos(input longint unsigned a, output longint sn,
                                         output longint cs);
    longint unsigned den, r, r2, t;
    den = 64'd180 << ANGLE_FRAC_BITS;
    r   = (a * PiQ30Const + den / 2) / den;
    r2  = mul_q30(r, r);
    t = OneQ30Val;
    t = OneQ30Val - mul_q30(r2, t) / 72;
    t = OneQ30Val - mul_q30(r2, t) / 42;
    t = OneQ30Val - mul_q30(r2, t) / 20;
    t = OneQ30Val - mul_q30(r2, t) / 6;
    sn = round_to_trig(mul_q30(r, t));
    t = OneQ30Val;
    t = OneQ30Val - mul_q30(r2, t) / 90;
    t = OneQ30Val - mul_q30(r2, t) / 56;
    t = OneQ30Val - mul_q30(r2, t) / 30;
    t = OneQ30Val - mul_q30(r2, t) / 12;
    t = OneQ30Val - mul_q30(r2, t) / 2;
    cs = round_to_trig(t);
  endfunction

  function automatic longint div_round_away(longint n, longint d);
    longint mag;
    mag = (n < 0) ? -n : n;
    mag = (mag + d / 2) / d;
    return (n < 0) ? -mag : mag;
  endfunction

  function automatic longint cubic_curve(longint v);
    longint w;
    w = div_round_away(v, longint'(1) << (TRIG_FRAC_BITS - 8));
    return div_round_away(w * w * w + 64'sd655360000 * w, 64'sd31457280000);
  endfunction

  function automatic logic signed [11:0] clamp_power(longint p);
    if (p > PowerLimit) p = PowerLimit;
    if (p < -PowerLimit) p = -PowerLimit;
    return p[11:0];
  endfunction

  function automatic fodm_out_t mix_powers(fodm_in_t d, logic [12:0] hdg);
    longint err, a, s, c, x, y, lp, rp, ht;
    bit     sneg, cneg;
    fodm_out_t o;
    err = (longint'(hdg) - longint'(d.rotation_angle)) % FullTurn;
    if (err < 0) err += FullTurn;
    if (err > HalfTurn) err -= FullTurn;
    sneg = err < 0;
    cneg = 1'b0;
    a = sneg ? -err : err;
    if (a > QuarterTurn) begin
      a = HalfTurn - a;
      cneg = 1'b1;
    end
    if (a > EighthTurn) octant_sin_cos(longint'(QuarterTurn) - a, c, s);
    else octant_sin_cos(a, s, c);
    if (sneg) s = -s;
    if (cneg) c = -c;
    x  = -longint'(d.stick_side);
    y  = longint'(d.stick_forward);
    lp = cubic_curve(x * c - y * s);
    rp = cubic_curve(x * s + y * c);
    ht = longint'(d.stick_turn) * 8;
    o.north_power = clamp_power(lp + ht);
    o.south_power = clamp_power(lp - ht);
    o.east_power  = clamp_power(rp + ht);
    o.west_power  = clamp_power(rp - ht);
    return o;
  endfunction

  // ---------------- monitors ----------------
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      pending_powers.push_back(mix_powers(in_data, heading));
  end

  always @(posedge clk) begin
    fodm_out_t exp_o;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_powers.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        fail_cnt++;
      end else begin
        exp_o = pending_powers.pop_front();
        if (exp_o.north_power !== out_data.north_power) begin
          $display("%0t: north exp %0d got %0d", $time, exp_o.north_power,
                   out_data.north_power);
          fail_cnt++;
        end
        if (exp_o.south_power !== out_data.south_power) begin
          $display("%0t: south exp %0d got %0d", $time, exp_o.south_power,
                   out_data.south_power);
          fail_cnt++;
        end
        if (exp_o.east_power !== out_data.east_power) begin
          $display("%0t: east exp %0d got %0d", $time, exp_o.east_power,
                   out_data.east_power);
          fail_cnt++;
        end
        if (exp_o.west_power !== out_data.west_power) begin
          $display("%0t: west exp %0d got %0d", $time, exp_o.west_power,
                   out_data.west_power);
          fail_cnt++;
        end
      end
    end
  end

  // receiver: random stall bursts, plus one long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_start) begin
      out_stall  <= 1'b1;
      stall_left <= 400;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------- sender ----------------
  task automatic send_sample(fodm_in_t d);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_powers.size() != 0) @(posedge clk);
    repeat (Latency + 8) @(posedge clk);
  endtask

  task automatic set_heading(logic [12:0] h);
    drain_outputs();
    cfg_we    <= 1'b1;
    cfg_wdata <= h;
    heading   <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic signed [7:0] rand_stick();
    if ($urandom_range(0, 9) < 8) return 8'($signed($urandom_range(0, 200)) - 100);
    return 8'($urandom);
  endfunction

  function automatic fodm_in_t rand_sample();
    fodm_in_t d;
    d.rotation_angle = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($signed($urandom_range(0, 23040)) - 11520);
    d.stick_forward  = rand_stick();
    d.stick_side     = rand_stick();
    d.stick_turn     = rand_stick();
    return d;
  endfunction

  function automatic fodm_in_t make_sample(int rot, int fwd, int side, int turn);
    fodm_in_t d;
    d.rotation_angle = 16'(rot);
    d.stick_forward  = 8'(fwd);
    d.stick_side     = 8'(side);
    d.stick_turn     = 8'(turn);
    return d;
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed();
    // half-turn error wraps to plus 180; octant and quadrant edges; extremes
    send_sample(make_sample(0, 100, 0, 0));
    send_sample(make_sample(-2880, 100, 50, 0));
    send_sample(make_sample(2880, -100, 50, 0));
    send_sample(make_sample(720, 100, 100, 0));
    send_sample(make_sample(-720, 100, -100, 0));
    send_sample(make_sample(1440, 60, 30, 0));
    send_sample(make_sample(-1440, 60, 30, 0));
    send_sample(make_sample(721, 100, 0, 0));
    send_sample(make_sample(1441, 0, 100, 0));
    send_sample(make_sample(-32768, 127, -128, 127));
    send_sample(make_sample(32767, -128, 127, -128));
    send_sample(make_sample(5760, 100, 100, 100));
    send_sample(make_sample(0, 100, -100, -100));
    send_sample(make_sample(0, -100, -100, 100));
    send_sample(make_sample(0, 0, 0, 127));
    send_sample(make_sample(0, 0, 0, -128));
    send_sample(make_sample(1, -1, 1, 1));
    send_sample(make_sample(-1, 1, -1, -1));
    send_sample(make_sample(11520, 127, 127, 0));
    send_sample(make_sample(-11521, -128, -128, 0));
  endtask

  task automatic test_headings();
    logic [12:0] list[5] = '{13'd5759, 13'd8191, 13'd2880, 13'd1, 13'd0};
    foreach (list[i]) begin
      set_heading(list[i]);
      send_sample(make_sample(int'(list[i]), 100, 0, 0));
      send_sample(make_sample(int'(list[i]) - 2880, 100, 0, 0));
      repeat (20) send_sample(rand_sample());
    end
  endtask

  task automatic test_backpressure();
    in_valid   <= 1'b0;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    repeat (80) send_sample(rand_sample());
    // pause until everything in flight has come out
    drain_outputs();
    repeat (30) send_sample(rand_sample());
  endtask

  task automatic test_random();
    for (int i = 0; i < 1110; i++) begin
      if (i % 250 == 0) set_heading(13'($urandom));
      if (i == 900) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      send_sample(rand_sample());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    test_directed();
    test_headings();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_powers.size() != 0) @(posedge clk);
    repeat (Latency + 8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
